[design/pac_arb_pkg.sv]
package pac_arb_pkg;

    localparam int NUM_OBJECTS    = 4;
    localparam int NUM_PRIORITIES = 16;

    localparam int SLOT_W    = $clog2(NUM_PRIORITIES);
    localparam int OBJ_W     = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int ADDR_W    = OBJ_W + SLOT_W;
    localparam int MEM_DEPTH = NUM_OBJECTS * NUM_PRIORITIES;

    localparam int INST_W  = 22;
    localparam int PRIO_W  = 5;
    localparam int LEVEL_W = 16;
    localparam int PV_W    = 7;
    localparam int ERR_W   = 3;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX_FIXED   = 16'd25600;
    localparam logic [PV_W-1:0]    LEVEL_SAT         = 7'd100;
    localparam logic [PRIO_W-1:0]  RESERVED_PRIORITY = 5'd6;

    // Word index of the relinquish-default register (paddr bit 2).
    localparam logic REG_RELINQ_DEFAULT = 1'b0;

    typedef enum logic [1:0] {
        FUNC_COMMAND    = 2'd0,
        FUNC_RELINQUISH = 2'd1,
        FUNC_SET_OOS    = 2'd2,
        FUNC_READ       = 2'd3
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE         = 3'd0,
        ERR_UNKNOWN_OBJ  = 3'd1,
        ERR_ACCESS_DENY  = 3'd2,
        ERR_OUT_OF_RANGE = 3'd3,
        ERR_BAD_SLOT     = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_PV,
        ST_SLOT,
        ST_DONE
    } state_t;

endpackage

[design/priority_array_command_arbiter.sv]
// Channel    Direction  Handshake          Payload
// s_*        in         s_valid / s_ready  func, instance, priority, level, flag
// m_*        out        m_valid / m_ready  status, present value, slot readback
// apb        in         psel/penable       relinquish default (word 0)
//
// A request passes from its transfer to its registered result through these
// steps: the change is applied, the priority scan examines slots (1 to 16,
// stopping at the first non-null slot), two reads go through the registered
// port of the slot memory, and the output register is loaded. A request for
// an unknown object skips the scan and the slot reads. Reset is synchronous
// and active low; it clears the non-null flags, the service flags and the
// relinquish default, so no clearing pass is needed. The result sits in an
// output register, so a new request is taken while an earlier result still
// waits on m_ready.
module priority_array_command_arbiter (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic [pac_arb_pkg::INST_W-1:0]     s_instance_req,
    input  logic [pac_arb_pkg::PRIO_W-1:0]     s_priority_req,
    input  logic [pac_arb_pkg::LEVEL_W-1:0]    s_level_value,
    input  logic                               s_flag_value,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic [pac_arb_pkg::ERR_W-1:0]      m_fault_code,
    output logic [pac_arb_pkg::PV_W-1:0]       m_present_value,
    output logic [pac_arb_pkg::PRIO_W-1:0]     m_active_priority,
    output logic                               m_out_of_service,
    output logic [pac_arb_pkg::PV_W-1:0]       m_slot_level,
    output logic                               m_slot_is_null,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pac_arb_pkg::APB_AW-1:0]     paddr,
    input  logic [pac_arb_pkg::APB_DW-1:0]     pwdata,
    output logic [pac_arb_pkg::APB_DW-1:0]     prdata,
    output logic                               pready
);
    import pac_arb_pkg::*;

    state_t state_reg, state_next;

    // Request captured at the input transfer.
    func_t               func_reg;
    logic [OBJ_W-1:0]    obj_reg;
    logic                known_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic                level_ok_reg;
    logic [PV_W-1:0]     level_int_reg;
    logic                flag_reg;

    // Slot storage: levels in a memory, null state in flip-flops so that
    // reset makes every slot null at once.
    logic [PV_W-1:0]      mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] nn_reg;
    logic [PV_W-1:0]      rd_data_reg;
    logic [NUM_OBJECTS-1:0] oos_reg;
    logic [PV_W-1:0]      relinq_reg;

    logic [SLOT_W-1:0]   idx_reg;
    logic                found_reg;

    logic                ok_reg;
    err_t                err_reg;
    logic [PV_W-1:0]     pv_reg;
    logic [PRIO_W-1:0]   act_reg;
    logic [PV_W-1:0]     sl_reg;
    logic                sn_reg;

    logic                s_xfer;
    logic                m_load;
    logic                cfg_wr;
    logic                prio_valid;
    logic [SLOT_W-1:0]   req_slot;
    logic [ADDR_W-1:0]   scan_addr;
    logic [ADDR_W-1:0]   req_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                scan_hit;
    logic                scan_last;
    logic                mem_we;
    logic                nn_set;
    logic                nn_clr;
    logic                oos_we;
    logic                exec_ok;
    err_t                exec_err;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign m_load  = (state_reg == ST_DONE) && (!m_valid || m_ready);

    // The configuration port has one register; paddr bit 2 selects the word.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RELINQ_DEFAULT);
    assign prdata = (paddr[2] == REG_RELINQ_DEFAULT) ?
                    {{(APB_DW-PV_W){1'b0}}, relinq_reg} : '0;

    assign prio_valid = (prio_reg != '0) && (prio_reg <= PRIO_W'(NUM_PRIORITIES));
    assign req_slot   = SLOT_W'(prio_reg - PRIO_W'(1));
    assign scan_addr  = {obj_reg, idx_reg};
    assign req_addr   = {obj_reg, req_slot};
    assign scan_hit   = nn_reg[scan_addr];
    assign scan_last  = (idx_reg == SLOT_W'(NUM_PRIORITIES - 1));
    assign rd_addr    = (state_reg == ST_SCAN) ? scan_addr : req_addr;

    // Checks and state updates of the request, applied in the execute cycle.
    always_comb begin
        exec_ok  = 1'b0;
        exec_err = ERR_NONE;
        mem_we   = 1'b0;
        nn_set   = 1'b0;
        nn_clr   = 1'b0;
        oos_we   = 1'b0;
        if (!known_reg) begin
            exec_err = ERR_UNKNOWN_OBJ;
        end else begin
            unique case (func_reg)
                FUNC_COMMAND: begin
                    if (prio_reg == RESERVED_PRIORITY) begin
                        exec_err = ERR_ACCESS_DENY;
                    end else if (!prio_valid || !level_ok_reg) begin
                        exec_err = ERR_OUT_OF_RANGE;
                    end else begin
                        mem_we  = 1'b1;
                        nn_set  = 1'b1;
                        exec_ok = 1'b1;
                    end
                end
                FUNC_RELINQUISH: begin
                    if (!prio_valid || prio_reg == RESERVED_PRIORITY) begin
                        exec_err = ERR_OUT_OF_RANGE;
                    end else begin
                        nn_clr  = 1'b1;
                        exec_ok = 1'b1;
                    end
                end
                FUNC_SET_OOS: begin
                    oos_we  = 1'b1;
                    exec_ok = 1'b1;
                end
                FUNC_READ: begin
                    if (prio_valid) begin
                        exec_ok = 1'b1;
                    end else begin
                        exec_err = ERR_BAD_SLOT;
                    end
                end
                default: begin
                    exec_err = ERR_NONE;
                end
            endcase
        end
    end

    // Sequencer: the scan walks the slots from the highest priority down,
    // one compare per cycle, and stops at the first non-null slot.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = known_reg ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = ST_PV;
                end
            end
            ST_PV: begin
                state_next = ST_SLOT;
            end
            ST_SLOT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Slot memory: one write port, one read port with registered data.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && mem_we) begin
            mem[req_addr] <= level_int_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nn_reg     <= '0;
            oos_reg    <= '0;
            relinq_reg <= '0;
        end else begin
            if (state_reg == ST_EXEC) begin
                if (nn_set) begin
                    nn_reg[req_addr] <= 1'b1;
                end
                if (nn_clr) begin
                    nn_reg[req_addr] <= 1'b0;
                end
                if (oos_we) begin
                    oos_reg[obj_reg] <= flag_reg;
                end
            end
            if (cfg_wr) begin
                relinq_reg <= (pwdata[PV_W-1:0] > LEVEL_SAT) ? LEVEL_SAT : pwdata[PV_W-1:0];
            end
        end
    end

    // Request capture and result assembly.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            func_reg      <= func_t'(s_func);
            obj_reg       <= s_instance_req[OBJ_W-1:0];
            known_reg     <= (s_instance_req < INST_W'(NUM_OBJECTS));
            prio_reg      <= s_priority_req;
            level_ok_reg  <= (s_level_value <= LEVEL_MAX_FIXED);
            level_int_reg <= s_level_value[8 +: PV_W];
            flag_reg      <= s_flag_value;
        end
        unique case (state_reg)
            ST_EXEC: begin
                ok_reg  <= exec_ok;
                err_reg <= exec_err;
                pv_reg  <= relinq_reg;
                act_reg <= '0;
                sl_reg  <= '0;
                sn_reg  <= 1'b1;
                idx_reg <= '0;
            end
            ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    found_reg <= scan_hit;
                    act_reg   <= scan_hit ? (PRIO_W'(idx_reg) + PRIO_W'(1)) : '0;
                end else begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                end
            end
            ST_PV: begin
                pv_reg <= found_reg ? rd_data_reg : relinq_reg;
            end
            ST_SLOT: begin
                if (prio_valid && nn_reg[req_addr]) begin
                    sl_reg <= rd_data_reg;
                    sn_reg <= 1'b0;
                end
            end
            ST_IDLE, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (m_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_ok              <= ok_reg;
            m_fault_code      <= err_reg;
            m_present_value   <= pv_reg;
            m_active_priority <= act_reg;
            m_out_of_service  <= known_reg ? oos_reg[obj_reg] : 1'b0;
            m_slot_level      <= sl_reg;
            m_slot_is_null    <= sn_reg;
        end
    end

endmodule

[test/testbench.sv]
// Self-checking bench for the priority-array command arbiter.

module testbench;

    import pac_arb_pkg::*;

    // One request as it crosses the s_ channel.
    typedef struct packed {
        func_t                func;
        logic [INST_W-1:0]    inst;
        logic [PRIO_W-1:0]    prio;
        logic [LEVEL_W-1:0]   level;
        logic                 flag;
    } request_t;

    // The status and readback that one request should produce on the m_ channel.
    typedef struct packed {
        logic                 ok;
        err_t                 err;
        logic [PV_W-1:0]      pv;
        logic [PRIO_W-1:0]    act;
        logic                 oos;
        logic [PV_W-1:0]      sl;
        logic                 sn;
    } outcome_t;

    // A slot that holds no command. Stored levels never exceed 100.
    localparam logic [7:0] LEVEL_EMPTY = 8'hFF;
    localparam logic [APB_AW-1:0] RELINQ_DEFAULT_ADDR = {REG_RELINQ_DEFAULT, 2'b00};
    localparam int ITEMS_PER_PHASE = 310;
    localparam int SETTLE_CYCLES = 25;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_func = FUNC_READ;
    logic [INST_W-1:0]      s_instance_req = '0;
    logic [PRIO_W-1:0]      s_priority_req = '0;
    logic [LEVEL_W-1:0]     s_level_value = '0;
    logic                   s_flag_value = 1'b0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_ok;
    logic [ERR_W-1:0]       m_fault_code;
    logic [PV_W-1:0]        m_present_value;
    logic [PRIO_W-1:0]      m_active_priority;
    logic                   m_out_of_service;
    logic [PV_W-1:0]        m_slot_level;
    logic                   m_slot_is_null;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    priority_array_command_arbiter DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_instance_req    (s_instance_req),
        .s_priority_req    (s_priority_req),
        .s_level_value     (s_level_value),
        .s_flag_value      (s_flag_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_fault_code      (m_fault_code),
        .m_present_value   (m_present_value),
        .m_active_priority (m_active_priority),
        .m_out_of_service  (m_out_of_service),
        .m_slot_level      (m_slot_level),
        .m_slot_is_null    (m_slot_is_null),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Our own copy of the arbiter state. It is updated when a request
    // transfer happens, so it always matches what the block has seen.
    logic [7:0]         slot_table [0:NUM_OBJECTS-1][0:NUM_PRIORITIES-1];
    logic               service_table [0:NUM_OBJECTS-1];
    logic [PV_W-1:0]    relinquish_dflt;

    request_t           pending_requests[$];
    outcome_t           expected_outcomes[$];
    request_t           current_request;

    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 requests_queued = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 settings_written = 0;
    int                 func_count [0:3];
    int                 refusal_count [0:4];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one request to the state copy and returns what the block
    // must report afterwards. The result shows the state after the change.
    function automatic outcome_t apply_request(input request_t rq);
        outcome_t   o;
        logic       prio_ok;
        int         obj;
        int         idx;
        int         p;

        o.ok  = 1'b0;
        o.err = ERR_NONE;
        o.pv  = relinquish_dflt;
        o.act = '0;
        o.oos = 1'b0;
        o.sl  = '0;
        o.sn  = 1'b1;
        prio_ok = (rq.prio >= 1) && (rq.prio <= NUM_PRIORITIES);
        idx = int'(rq.prio) - 1;

        if (rq.inst >= NUM_OBJECTS) begin
            // An unknown object changes nothing and reports default values.
            o.err = ERR_UNKNOWN_OBJ;
        end else begin
            obj = int'(rq.inst);
            case (rq.func)
                FUNC_COMMAND: begin
                    // The reserved priority is refused before the level is looked at.
                    if (rq.prio == RESERVED_PRIORITY) begin
                        o.err = ERR_ACCESS_DENY;
                    end else if (!prio_ok || rq.level > LEVEL_MAX_FIXED) begin
                        o.err = ERR_OUT_OF_RANGE;
                    end else begin
                        slot_table[obj][idx] = {1'b0, rq.level[LEVEL_W-2:8]};
                        o.ok = 1'b1;
                    end
                end
                FUNC_RELINQUISH: begin
                    if (!prio_ok || rq.prio == RESERVED_PRIORITY) begin
                        o.err = ERR_OUT_OF_RANGE;
                    end else begin
                        slot_table[obj][idx] = LEVEL_EMPTY;
                        o.ok = 1'b1;
                    end
                end
                FUNC_SET_OOS: begin
                    service_table[obj] = rq.flag;
                    o.ok = 1'b1;
                end
                default: begin
                    if (prio_ok) begin
                        o.ok = 1'b1;
                    end else begin
                        o.err = ERR_BAD_SLOT;
                    end
                end
            endcase

            // Scanning from the lowest priority upward leaves the most
            // urgent non-null slot as the winner.
            for (p = NUM_PRIORITIES - 1; p >= 0; p--) begin
                if (slot_table[obj][p] != LEVEL_EMPTY) begin
                    o.pv  = slot_table[obj][p][PV_W-1:0];
                    o.act = PRIO_W'(p + 1);
                end
            end
            o.oos = service_table[obj];
            if (prio_ok && slot_table[obj][idx] != LEVEL_EMPTY) begin
                o.sl = slot_table[obj][idx][PV_W-1:0];
                o.sn = 1'b0;
            end
        end
        return o;
    endfunction

    // Request driver. A held request stays on the bus until its transfer.
    // The next request is chosen in the same step, so s_valid gets at most
    // one assignment per edge.
    always @(posedge aclk) begin : request_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(apply_request(current_request));
                func_count[current_request.func]++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 &&
                        $urandom_range(99) >= sender_idle_pct) begin
                    current_request = pending_requests.pop_front();
                    s_valid        <= 1'b1;
                    s_func         <= current_request.func;
                    s_instance_req <= current_request.inst;
                    s_priority_req <= current_request.prio;
                    s_level_value  <= current_request.level;
                    s_flag_value   <= current_request.flag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result monitor. Each result transfer is matched against the oldest
    // outstanding expectation, and m_ready is stalled at random.
    always @(posedge aclk) begin : result_monitor
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result transfer with no request outstanding", $time);
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (want.err != ERR_NONE) begin
                        refusal_count[want.err]++;
                    end
                    compare_field("ok", 32'(want.ok), 32'(m_ok));
                    compare_field("fault_code", 32'(want.err), 32'(m_fault_code));
                    compare_field("present_value", 32'(want.pv), 32'(m_present_value));
                    compare_field("active_priority", 32'(want.act),
                                  32'(m_active_priority));
                    compare_field("out_of_service", 32'(want.oos), 32'(m_out_of_service));
                    compare_field("slot_level", 32'(want.sl), 32'(m_slot_level));
                    compare_field("slot_is_null", 32'(want.sn), 32'(m_slot_is_null));
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Writes the relinquish default through the register port. The value
    // is captured at the edge of the access cycle, and values above 100
    // saturate to 100.
    task automatic write_relinquish_default(input logic [APB_DW-1:0] value);
        logic [PV_W-1:0] raw;
        raw = value[PV_W-1:0];
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RELINQ_DEFAULT_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        relinquish_dflt = (raw > LEVEL_SAT) ? LEVEL_SAT : raw;
        settings_written++;
    endtask

    task automatic queue_request(input func_t func, input logic [INST_W-1:0] inst,
                                 input logic [PRIO_W-1:0] prio,
                                 input logic [LEVEL_W-1:0] level, input logic flag);
        request_t rq;
        rq.func  = func;
        rq.inst  = inst;
        rq.prio  = prio;
        rq.level = level;
        rq.flag  = flag;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    // Random request, mostly well formed so that slots fill and empty
    // again, with some unknown objects, bad priorities and large levels.
    task automatic queue_random_request();
        func_t              func;
        logic [INST_W-1:0]  inst;
        logic [PRIO_W-1:0]  prio;
        logic [LEVEL_W-1:0] level;
        int                 pick;

        pick = $urandom_range(99);
        if (pick < 35) func = FUNC_COMMAND;
        else if (pick < 65) func = FUNC_RELINQUISH;
        else if (pick < 75) func = FUNC_SET_OOS;
        else func = FUNC_READ;

        pick = $urandom_range(99);
        if (pick < 86) inst = INST_W'($urandom_range(NUM_OBJECTS - 1));
        else if (pick < 92) inst = INST_W'($urandom_range(NUM_OBJECTS + 3, NUM_OBJECTS));
        else if (pick < 98) inst = INST_W'($urandom);
        else inst = '1;

        if ($urandom_range(99) < 80) prio = PRIO_W'($urandom_range(NUM_PRIORITIES, 1));
        else prio = PRIO_W'($urandom_range(31));

        pick = $urandom_range(9);
        if (pick == 0) level = LEVEL_W'($urandom);
        else if (pick == 1) level = LEVEL_MAX_FIXED + LEVEL_W'($urandom_range(2));
        else level = LEVEL_W'($urandom_range(LEVEL_MAX_FIXED));

        queue_request(func, inst, prio, level, 1'($urandom));
    endtask

    // Waits until every queued request has produced its checked result.
    task automatic wait_all_results();
        while (results_seen < requests_queued) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [APB_DW-1:0] setting);
        int n;
        write_relinquish_default(setting);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            queue_random_request();
        end
        wait_all_results();
    endtask

    initial begin : main_sequence
        int o;
        int p;

        for (o = 0; o < NUM_OBJECTS; o++) begin
            service_table[o] = 1'b0;
            for (p = 0; p < NUM_PRIORITIES; p++) begin
                slot_table[o][p] = LEVEL_EMPTY;
            end
        end
        relinquish_dflt = '0;
        for (o = 0; o < 4; o++) func_count[o] = 0;
        for (o = 0; o < 5; o++) refusal_count[o] = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // A raw value of 127 must saturate to 100.
        write_relinquish_default(32'h0000_007F);

        // Directed requests: field extremes, each function, each refusal.
        queue_request(FUNC_READ, 2, 1, 0, 1'b0);                  // all null, default shows
        queue_request(FUNC_COMMAND, 0, 1, LEVEL_MAX_FIXED, 1'b0); // exactly 100.0
        queue_request(FUNC_COMMAND, 0, 2, LEVEL_MAX_FIXED + LEVEL_W'(1), 1'b0);
        queue_request(FUNC_COMMAND, 0, 3, 16'hFFFF, 1'b1);
        queue_request(FUNC_COMMAND, 0, RESERVED_PRIORITY, 16'hFFFF, 1'b0);
        queue_request(FUNC_COMMAND, 1, 0, 16'h1000, 1'b0);
        queue_request(FUNC_COMMAND, 1, 17, 16'h1000, 1'b0);
        queue_request(FUNC_COMMAND, 1, 31, 16'h1000, 1'b0);
        queue_request(FUNC_COMMAND, 1, 16, 16'h0000, 1'b0);       // level zero, lowest prio
        queue_request(FUNC_COMMAND, 1, 9, 16'h32FF, 1'b0);        // fraction truncated
        queue_request(FUNC_READ, 1, 16, 0, 1'b0);
        queue_request(FUNC_READ, 1, 0, 0, 1'b0);
        queue_request(FUNC_READ, 1, 31, 0, 1'b0);
        queue_request(FUNC_RELINQUISH, 0, RESERVED_PRIORITY, 0, 1'b0);
        queue_request(FUNC_RELINQUISH, 0, 0, 0, 1'b0);
        queue_request(FUNC_RELINQUISH, 0, 31, 0, 1'b0);
        queue_request(FUNC_RELINQUISH, 0, 1, 0, 1'b0);
        queue_request(FUNC_SET_OOS, 3, 31, 16'hFFFF, 1'b1);      // priority ignored
        queue_request(FUNC_SET_OOS, 3, 0, 0, 1'b0);
        queue_request(FUNC_SET_OOS, 2, 5, 0, 1'b1);
        queue_request(FUNC_COMMAND, INST_W'(NUM_OBJECTS), 1, 16'h1000, 1'b0);
        queue_request(FUNC_RELINQUISH, 22'h3FFFFF, 1, 0, 1'b0);
        queue_request(FUNC_SET_OOS, 22'h2AAAAA, 1, 0, 1'b1);
        queue_request(FUNC_READ, 22'h3FFFFF, 31, 16'hFFFF, 1'b1);
        wait_all_results();

        // Random phases, each under its own default setting and idling mix.
        run_random_phase(0, 0, 32'hFFFF_FF80);
        run_random_phase(47, 0, 32'd100);
        run_random_phase(0, 47, APB_DW'($urandom_range(100)));
        run_random_phase(26, 26, 32'd101);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_outcomes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_outcomes.size());
            mismatches++;
        end

        $display("Covered %0d requests: %0d commands, %0d relinquishes, %0d service sets,",
                 results_seen, func_count[FUNC_COMMAND], func_count[FUNC_RELINQUISH],
                 func_count[FUNC_SET_OOS]);
        $display("%0d reads; refusals: unknown %0d, denied %0d, range %0d, slot %0d; %0d %s",
                 func_count[FUNC_READ], refusal_count[ERR_UNKNOWN_OBJ],
                 refusal_count[ERR_ACCESS_DENY], refusal_count[ERR_OUT_OF_RANGE],
                 refusal_count[ERR_BAD_SLOT], settings_written, "default writes.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog. The slowest correct run is far below this bound.
    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
